>>> hw/rtl/cdci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdci_pkg
// Shared types, command codes and constants of the drive host interface.
// ----------------------------------------------------------------------------
package cdci_pkg;

    localparam int SECTOR_BUFFER_BYTES = 2340;
    localparam int FIFO_DEPTH          = 16;

    localparam logic [7:0] CMD_GETSTAT = 8'h01;
    localparam logic [7:0] CMD_SETLOC  = 8'h02;
    localparam logic [7:0] CMD_READN   = 8'h06;
    localparam logic [7:0] CMD_PAUSE   = 8'h09;
    localparam logic [7:0] CMD_INIT    = 8'h0A;
    localparam logic [7:0] CMD_DEMUTE  = 8'h0C;
    localparam logic [7:0] CMD_SETMODE = 8'h0E;
    localparam logic [7:0] CMD_SEEKL   = 8'h15;
    localparam logic [7:0] CMD_TEST    = 8'h19;
    localparam logic [7:0] CMD_GETID   = 8'h1A;
    localparam logic [7:0] CMD_READTOC = 8'h1E;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_DISC  = 2'd2;
    localparam logic [1:0] OP_FLAGS = 2'd3;

    localparam logic [1:0] IRQ_DATA_READY = 2'd1;
    localparam logic [1:0] IRQ_COMPLETE   = 2'd2;
    localparam logic [1:0] IRQ_ACK        = 2'd3;

    localparam logic [31:0] BYTES_PER_FRAME  = 32'd2352;
    localparam logic [31:0] BYTES_PER_SECOND = 32'd176400;
    localparam logic [31:0] BYTES_PER_MINUTE = 32'd10584000;
    localparam logic [11:0] LEN_WHOLE  = 12'h924;
    localparam logic [11:0] LEN_DATA   = 12'h800;
    localparam int          FILL_WHOLE = 'h920;
    localparam int          FILL_DATA  = 'h7F8;
    localparam logic [7:0]  TEST_ARG   = 8'h20;

    localparam int FLAG_READING = 0;
    localparam int FLAG_SEEKING = 1;
    localparam int FLAG_PLAYING = 2;
    localparam int MODE_WHOLE   = 5;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_update;
        logic [1:0]  irq_number;
        logic        irq_enabled;
        logic        disc_request;
        logic [31:0] disc_address;
        logic [11:0] disc_length;
    } t_result;

    typedef struct packed {
        logic use_ram;
        logic force_zero;
    } t_rd_sel;

    function automatic logic [7:0] status_byte(input logic [2:0] flags, input logic no_disc);
        status_byte = {flags[FLAG_PLAYING], flags[FLAG_SEEKING], flags[FLAG_READING],
                       no_disc, 4'b0010};
    endfunction

    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        bcd_value = 8'({4'd0, b[3:0]} + {4'd0, b[7:4]} * 8'd10);
    endfunction

endpackage

>>> hw/rtl/cdci_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2340
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cdci_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdci_ctrl
// Register file, FIFOs and command sequencer; drives the sector RAM ports.
// ----------------------------------------------------------------------------
module cdci_ctrl #(
    parameter int SECTOR_BUFFER_BYTES = cdci_pkg::SECTOR_BUFFER_BYTES,
    localparam int ADDR_W = $clog2(SECTOR_BUFFER_BYTES),
    localparam int CNT_W  = $clog2(SECTOR_BUFFER_BYTES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_operation,
    input  logic [1:0]        i_port,
    input  logic [7:0]        i_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output cdci_pkg::t_result o_result,
    output cdci_pkg::t_rd_sel o_rd_sel,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_waddr,
    output logic [7:0]        o_ram_wdata,
    output logic              o_ram_re,
    output logic [ADDR_W-1:0] o_ram_raddr
);

    localparam int FD = cdci_pkg::FIFO_DEPTH;

    logic              r_no_disc;
    logic [1:0]        r_port_index, n_port_index;
    logic [7:0]        r_param [FD];
    logic [7:0]        n_param [FD];
    logic [4:0]        r_param_cnt, n_param_cnt;
    logic [7:0]        r_resp [FD];
    logic [7:0]        n_resp [FD];
    logic [4:0]        r_resp_cnt, n_resp_cnt;
    logic [3:0]        r_resp_rd, n_resp_rd;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_sec_rd, n_sec_rd;
    logic [4:0]        r_irq_en, n_irq_en;
    logic [7:0]        r_irq_flag, n_irq_flag;
    logic              r_busy, n_busy;
    logic [7:0]        r_cmd, n_cmd;
    logic              r_second, n_second;
    logic [2:0]        r_flags, n_flags;
    logic [7:0]        r_mode, n_mode;
    logic [31:0]       r_pos, n_pos;
    logic              r_pos_used, n_pos_used;
    logic              r_consumed, n_consumed;

    always_comb begin
        logic        do_stage;
        logic        second;
        logic [7:0]  cmd;
        logic [3:0]  push_n;
        logic [7:0]  pb [8];
        logic        irq;
        logic [1:0]  irq_n;
        logic        clr_p;
        logic        clr_r;
        logic [4:0]  cnt;
        logic [4:0]  nxt;
        logic [31:0] pos_calc;
        logic        whole;
        logic [CNT_W-1:0] fix;

        n_port_index = r_port_index;
        n_param      = r_param;
        n_param_cnt  = r_param_cnt;
        n_resp       = r_resp;
        n_resp_cnt   = r_resp_cnt;
        n_resp_rd    = r_resp_rd;
        n_fill       = r_fill;
        n_sec_rd     = r_sec_rd;
        n_irq_en     = r_irq_en;
        n_irq_flag   = r_irq_flag;
        n_busy       = r_busy;
        n_cmd        = r_cmd;
        n_second     = r_second;
        n_flags      = r_flags;
        n_mode       = r_mode;
        n_pos        = r_pos;
        n_pos_used   = r_pos_used;
        n_consumed   = r_consumed;

        o_result     = '0;
        o_rd_sel     = '0;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_fill[ADDR_W-1:0];
        o_ram_wdata  = i_data;
        o_ram_re     = 1'b0;
        o_ram_raddr  = r_sec_rd[ADDR_W-1:0];

        do_stage = 1'b0;
        second   = 1'b0;
        cmd      = i_data;
        push_n   = '0;
        for (int j = 0; j < 8; j++) pb[j] = '0;
        irq      = 1'b0;
        irq_n    = '0;
        clr_p    = 1'b0;
        clr_r    = 1'b0;
        whole    = r_mode[cdci_pkg::MODE_WHOLE];
        fix      = whole ? CNT_W'(cdci_pkg::FILL_WHOLE) : CNT_W'(cdci_pkg::FILL_DATA);
        nxt      = {1'b0, r_resp_rd} + 5'd1;
        pos_calc = 32'({24'd0, cdci_pkg::bcd_value(r_param[2])} * cdci_pkg::BYTES_PER_FRAME)
                 + 32'({24'd0, cdci_pkg::bcd_value(r_param[1])} * cdci_pkg::BYTES_PER_SECOND)
                 + 32'({24'd0, cdci_pkg::bcd_value(r_param[0])} * cdci_pkg::BYTES_PER_MINUTE);

        case (i_operation)
            cdci_pkg::OP_READ: begin
                case (i_port)
                    2'd0: o_result.read_data = {r_busy, r_fill != '0, r_resp_cnt != '0,
                                                r_param_cnt != 5'(FD), r_param_cnt == '0,
                                                1'b0, r_port_index};
                    2'd1: begin
                        o_result.read_data = r_resp[r_resp_rd];
                        if (nxt == r_resp_cnt) n_resp_cnt = '0;
                        n_resp_rd = nxt[3:0];
                    end
                    2'd2: begin
                        o_ram_re = 1'b1;
                        o_rd_sel.use_ram = 1'b1;
                        if (r_sec_rd < r_fill &&
                            r_sec_rd < CNT_W'(SECTOR_BUFFER_BYTES)) begin
                            n_sec_rd = r_sec_rd + CNT_W'(1);
                        end else begin
                            o_ram_raddr = fix[ADDR_W-1:0];
                            o_rd_sel.force_zero = !(r_fill > fix);
                        end
                        n_consumed = 1'b1;
                    end
                    default: o_result.read_data = r_port_index[0] ?
                                                  {5'b11100, r_irq_flag[2:0]} :
                                                  {3'b111, r_irq_en};
                endcase
            end
            cdci_pkg::OP_WRITE: begin
                case (i_port)
                    2'd0: n_port_index = i_data[1:0];
                    2'd1: begin
                        if (r_port_index == 2'd0) begin
                            if (!r_busy) begin
                                clr_r    = 1'b1;
                                n_busy   = 1'b1;
                                n_cmd    = i_data;
                                do_stage = 1'b1;
                                second   = r_second;
                            end else if (i_data == cdci_pkg::CMD_PAUSE) begin
                                n_cmd    = i_data;
                                n_second = 1'b0;
                                do_stage = 1'b1;
                            end
                        end
                    end
                    2'd2: begin
                        if (r_port_index == 2'd0) begin
                            if (r_param_cnt < 5'(FD)) begin
                                n_param[r_param_cnt[3:0]] = i_data;
                                n_param_cnt = r_param_cnt + 5'd1;
                            end
                        end else if (r_port_index == 2'd1) begin
                            n_irq_en = i_data[4:0];
                        end
                    end
                    default: begin
                        if (r_port_index == 2'd0) begin
                            if (!i_data[7]) n_sec_rd = '0;
                        end else if (r_port_index == 2'd1) begin
                            if (i_data[6]) clr_p = 1'b1;
                            n_irq_flag = r_irq_flag & {3'b000, ~i_data[4:0]};
                            if (r_second) begin
                                clr_r    = 1'b1;
                                do_stage = 1'b1;
                                second   = 1'b1;
                                cmd      = r_cmd;
                            end
                        end
                    end
                endcase
            end
            cdci_pkg::OP_DISC: begin
                if (r_fill < CNT_W'(SECTOR_BUFFER_BYTES)) begin
                    o_ram_we = 1'b1;
                    n_fill   = r_fill + CNT_W'(1);
                end
            end
            default: n_irq_flag = i_data;
        endcase

        if (do_stage && !second) begin
            case (cmd)
                cdci_pkg::CMD_GETSTAT, cdci_pkg::CMD_DEMUTE: begin
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_busy = 1'b0; irq = 1'b1; irq_n = cdci_pkg::IRQ_ACK;
                end
                cdci_pkg::CMD_SETLOC: begin
                    n_pos = pos_calc; n_pos_used = 1'b0;
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_busy = 1'b0; irq = 1'b1; irq_n = cdci_pkg::IRQ_ACK;
                end
                cdci_pkg::CMD_READN: begin
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_flags[cdci_pkg::FLAG_READING] = 1'b1;
                    n_second = 1'b1; n_consumed = 1'b1;
                    irq = 1'b1; irq_n = cdci_pkg::IRQ_ACK;
                end
                cdci_pkg::CMD_PAUSE, cdci_pkg::CMD_GETID, cdci_pkg::CMD_READTOC: begin
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_second = 1'b1; irq = 1'b1; irq_n = cdci_pkg::IRQ_ACK;
                end
                cdci_pkg::CMD_INIT: begin
                    n_mode = '0;
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_second = 1'b1; irq = 1'b1; irq_n = cdci_pkg::IRQ_ACK;
                end
                cdci_pkg::CMD_SETMODE: begin
                    n_mode = r_param[0];
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_busy = 1'b0; irq = 1'b1; irq_n = cdci_pkg::IRQ_ACK;
                end
                cdci_pkg::CMD_SEEKL: begin
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_flags[cdci_pkg::FLAG_SEEKING] = 1'b1;
                    n_second = 1'b1; irq = 1'b1; irq_n = cdci_pkg::IRQ_ACK;
                end
                cdci_pkg::CMD_TEST: begin
                    clr_p = 1'b1;
                    if (r_param[0] == cdci_pkg::TEST_ARG) begin
                        push_n = 4'd4;
                        pb[0] = 8'h99; pb[1] = 8'h02; pb[2] = 8'h01; pb[3] = 8'hC3;
                        n_busy = 1'b0; irq = 1'b1; irq_n = cdci_pkg::IRQ_ACK;
                    end
                end
                default: ;
            endcase
        end else if (do_stage) begin
            case (cmd)
                cdci_pkg::CMD_READN: begin
                    if (r_consumed) begin
                        n_fill   = '0;
                        n_sec_rd = '0;
                        if (r_pos_used) n_pos = r_pos + cdci_pkg::BYTES_PER_FRAME;
                        else n_pos_used = 1'b1;
                        o_result.disc_request = 1'b1;
                        o_result.disc_address = n_pos + (whole ? 32'd12 : 32'd24);
                        o_result.disc_length  = whole ? cdci_pkg::LEN_WHOLE
                                                      : cdci_pkg::LEN_DATA;
                        n_consumed = 1'b0;
                    end
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_second = 1'b1; irq = 1'b1; irq_n = cdci_pkg::IRQ_DATA_READY;
                end
                cdci_pkg::CMD_PAUSE: begin
                    n_flags[cdci_pkg::FLAG_READING] = 1'b0;
                    n_flags[cdci_pkg::FLAG_PLAYING] = 1'b0;
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_busy = 1'b0; n_second = 1'b0;
                    irq = 1'b1; irq_n = cdci_pkg::IRQ_COMPLETE;
                end
                cdci_pkg::CMD_INIT, cdci_pkg::CMD_READTOC: begin
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_busy = 1'b0; n_second = 1'b0;
                    irq = 1'b1; irq_n = cdci_pkg::IRQ_COMPLETE;
                end
                cdci_pkg::CMD_SEEKL: begin
                    push_n = 4'd1; pb[0] = cdci_pkg::status_byte(n_flags, r_no_disc);
                    n_flags[cdci_pkg::FLAG_SEEKING] = 1'b0;
                    n_busy = 1'b0; n_second = 1'b0;
                    irq = 1'b1; irq_n = cdci_pkg::IRQ_COMPLETE;
                end
                cdci_pkg::CMD_GETID: begin
                    push_n = 4'd8;
                    pb[0] = 8'h02; pb[1] = 8'h00; pb[2] = 8'h20; pb[3] = 8'h00;
                    pb[4] = 8'h53; pb[5] = 8'h43; pb[6] = 8'h45; pb[7] = 8'h45;
                    n_busy = 1'b0; n_second = 1'b0;
                    irq = 1'b1; irq_n = cdci_pkg::IRQ_COMPLETE;
                end
                default: ;
            endcase
        end

        if (clr_r) begin
            for (int k = 0; k < FD; k++) n_resp[k] = '0;
            n_resp_cnt = '0;
            n_resp_rd  = '0;
        end
        cnt = n_resp_cnt;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < push_n && cnt < 5'(FD)) begin
                n_resp[cnt[3:0]] = pb[j];
                cnt = cnt + 5'd1;
            end
        end
        n_resp_cnt = cnt;

        if (irq) begin
            clr_p = 1'b1;
            o_result.irq_update  = 1'b1;
            o_result.irq_number  = irq_n;
            o_result.irq_enabled = (irq_n != 2'd0) &&
                                   ((r_irq_en[1:0] & irq_n) == irq_n);
        end
        if (clr_p) begin
            for (int k = 0; k < FD; k++) n_param[k] = '0;
            n_param_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_disc    <= 1'b1;
            r_port_index <= '0;
            for (int k = 0; k < FD; k++) begin
                r_param[k] <= '0;
                r_resp[k]  <= '0;
            end
            r_param_cnt  <= '0;
            r_resp_cnt   <= '0;
            r_resp_rd    <= '0;
            r_fill       <= '0;
            r_sec_rd     <= '0;
            r_irq_en     <= '0;
            r_irq_flag   <= '0;
            r_busy       <= 1'b0;
            r_cmd        <= '0;
            r_second     <= 1'b0;
            r_flags      <= '0;
            r_mode       <= '0;
            r_pos        <= '0;
            r_pos_used   <= 1'b0;
            r_consumed   <= 1'b1;
        end else begin
            if (i_cfg_we) r_no_disc <= i_cfg_wdata;
            if (i_accept) begin
                r_port_index <= n_port_index;
                r_param      <= n_param;
                r_param_cnt  <= n_param_cnt;
                r_resp       <= n_resp;
                r_resp_cnt   <= n_resp_cnt;
                r_resp_rd    <= n_resp_rd;
                r_fill       <= n_fill;
                r_sec_rd     <= n_sec_rd;
                r_irq_en     <= n_irq_en;
                r_irq_flag   <= n_irq_flag;
                r_busy       <= n_busy;
                r_cmd        <= n_cmd;
                r_second     <= n_second;
                r_flags      <= n_flags;
                r_mode       <= n_mode;
                r_pos        <= n_pos;
                r_pos_used   <= n_pos_used;
                r_consumed   <= n_consumed;
            end
        end
    end

endmodule

>>> hw/rtl/cdrom_controller_host_interface.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrom_controller_host_interface
// Host port block of an optical-drive controller: parameter and response
// FIFOs, command sequencing and a sector byte buffer in RAM.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A beat is taken every cycle while the output
// register is free or being drained; its result is registered there, beside
// the sector RAM's registered read data. The sector buffer is cleared
// through its fill count, so no clearing pass runs after reset.
module cdrom_controller_host_interface #(
    parameter int SECTOR_BUFFER_BYTES = cdci_pkg::SECTOR_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // port[1:0], data[9:2]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // read_data[7:0], irq_update[8], irq_number[10:9],
                                     // irq_enabled[11], disc_request[12],
                                     // disc_address[44:13], disc_length[56:45]
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata  // no_disc
);

    localparam int ADDR_W = $clog2(SECTOR_BUFFER_BYTES);

    logic              w_accept;
    cdci_pkg::t_result w_result;
    cdci_pkg::t_rd_sel w_rd_sel;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [7:0]        w_ram_wdata;
    logic              w_ram_re;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [7:0]        w_ram_rdata;

    logic              r_valid;
    cdci_pkg::t_result r_result;
    cdci_pkg::t_rd_sel r_rd_sel;
    logic [7:0]        w_read_data;

    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    cdci_ctrl #(
        .SECTOR_BUFFER_BYTES(SECTOR_BUFFER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_operation (i_s_tuser),
        .i_port      (i_s_tdata[1:0]),
        .i_data      (i_s_tdata[9:2]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (w_result),
        .o_rd_sel    (w_rd_sel),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr)
    );

    cdci_ram #(
        .WIDTH(8),
        .DEPTH(SECTOR_BUFFER_BYTES)
    ) u_sector_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we && w_accept),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re && w_accept),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
            r_rd_sel <= w_rd_sel;
        end
    end

    always_comb begin
        w_read_data = r_result.read_data;
        if (r_rd_sel.use_ram) begin
            w_read_data = r_rd_sel.force_zero ? 8'd0 : w_ram_rdata;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {7'd0, r_result.disc_length, r_result.disc_address,
                         r_result.disc_request, r_result.irq_enabled,
                         r_result.irq_number, r_result.irq_update, w_read_data};

endmodule
